[sv/smlbu_pkg.sv]
`default_nettype none

package smlbu_pkg;

  parameter int unsigned RstackDepth = 32;
  parameter int unsigned DataWidth   = 32;
  parameter int unsigned AddrWidth   = 16;

  parameter int unsigned FuncW    = 4;
  parameter int unsigned PortAddrW = 16;
  parameter int unsigned ValueW   = 32;
  parameter int unsigned DepthW   = 2;
  parameter int unsigned PopW     = 2;
  parameter int unsigned ErrW     = 2;
  parameter int unsigned InDataW  = 104;
  parameter int unsigned OutDataW = 24;

  typedef enum logic [3:0] {
    FUNC_JMP       = 4'd0,
    FUNC_JZ        = 4'd1,
    FUNC_JNZ       = 4'd2,
    FUNC_DO        = 4'd3,
    FUNC_PLUS_DO   = 4'd4,
    FUNC_MINUS_DO  = 4'd5,
    FUNC_LOOP      = 4'd6,
    FUNC_STEP_LOOP = 4'd7,
    FUNC_UNLOOP    = 4'd8,
    FUNC_OF        = 4'd9
  } func_e;

  typedef enum logic [1:0] {
    ERR_OK          = 2'd0,
    ERR_PARAM_UNDER = 2'd1,
    ERR_RET_OVER    = 2'd2,
    ERR_RET_UNDER   = 2'd3
  } err_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_PUSH
  } state_e;

  typedef struct packed {
    logic capture;
    logic exec;
    logic push_hi;
  } cmd_t;

  typedef struct packed {
    logic out_free;
    logic push_pend;
  } sts_t;

endpackage

`default_nettype wire

[sv/smlbu_ram.sv]
`default_nettype none

module smlbu_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 32,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic [AW-1:0]    raddr_a_i,
  input  wire logic [AW-1:0]    raddr_b_i,
  output logic      [WIDTH-1:0] rdata_a_o,
  output logic      [WIDTH-1:0] rdata_b_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_a_o <= mem_q[raddr_a_i];
    rdata_b_o <= mem_q[raddr_b_i];
  end

endmodule

`default_nettype wire

[sv/smlbu_dpath.sv]
`default_nettype none

module smlbu_dpath #(
  parameter int unsigned RSTACK_DEPTH = smlbu_pkg::RstackDepth,
  parameter int unsigned DATA_WIDTH   = smlbu_pkg::DataWidth,
  parameter int unsigned ADDR_WIDTH   = smlbu_pkg::AddrWidth
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire smlbu_pkg::cmd_t                 cmd_i,
  output smlbu_pkg::sts_t                      sts_o,
  input  wire logic [smlbu_pkg::FuncW-1:0]     in_user_i,
  input  wire logic [smlbu_pkg::InDataW-1:0]   in_data_i,
  output logic                                 out_valid_o,
  input  wire logic                            out_ready_i,
  output logic [smlbu_pkg::OutDataW-1:0]       out_data_o
);

  localparam int unsigned DW = DATA_WIDTH;
  localparam int unsigned AW = (ADDR_WIDTH < smlbu_pkg::PortAddrW) ? ADDR_WIDTH
                                                                   : smlbu_pkg::PortAddrW;
  localparam int unsigned CW = $clog2(RSTACK_DEPTH + 1);
  localparam int unsigned IW = (RSTACK_DEPTH > 1) ? $clog2(RSTACK_DEPTH) : 1;

  logic [smlbu_pkg::FuncW-1:0]      func_q;
  logic [smlbu_pkg::PortAddrW-1:0]  opaddr_q;
  logic [smlbu_pkg::PortAddrW-1:0]  target_q;
  logic signed [smlbu_pkg::ValueW-1:0] top_q;
  logic signed [smlbu_pkg::ValueW-1:0] second_q;
  logic [smlbu_pkg::DepthW-1:0]     depth_q;

  logic [CW-1:0] count_q, count_d;

  logic                          out_valid_q;
  logic [AW-1:0]                 next_q;
  logic [smlbu_pkg::PopW-1:0]    pops_q;
  smlbu_pkg::err_e               err_q;

  logic signed [DW-1:0] top, second, lim, idx_old, idx, step_v;
  logic [AW-1:0]        opaddr, tgt, skip, next;
  logic [smlbu_pkg::PopW-1:0] pops;
  smlbu_pkg::err_e      err;
  logic                 push, loop_wr, pop_pair, room, have_pair, is_step;
  logic                 out_free;

  logic          ram_we;
  logic [IW-1:0] ram_waddr, ram_raddr_a, ram_raddr_b;
  logic [DW-1:0] ram_wdata, ram_rdata_a, ram_rdata_b;

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      func_q   <= in_user_i;
      opaddr_q <= in_data_i[15:0];
      target_q <= in_data_i[31:16];
      top_q    <= in_data_i[63:32];
      second_q <= in_data_i[95:64];
      depth_q  <= in_data_i[97:96];
    end
  end

  assign top       = DW'(top_q);
  assign second    = DW'(second_q);
  assign lim       = $signed(ram_rdata_a);
  assign idx_old   = $signed(ram_rdata_b);
  assign opaddr    = opaddr_q[AW-1:0];
  assign tgt       = target_q[AW-1:0];
  assign skip      = opaddr + AW'(2);
  assign is_step   = (func_q == smlbu_pkg::FUNC_STEP_LOOP);
  assign step_v    = is_step ? top : DW'(1);
  assign idx       = idx_old + step_v;
  assign room      = ({1'b0, count_q} + (CW + 1)'(2)) <= (CW + 1)'(RSTACK_DEPTH);
  assign have_pair = (count_q >= CW'(2));

  always_comb begin
    next     = opaddr;
    pops     = '0;
    err      = smlbu_pkg::ERR_OK;
    push     = 1'b0;
    loop_wr  = 1'b0;
    pop_pair = 1'b0;
    case (func_q)
      smlbu_pkg::FUNC_JMP: begin
        next = tgt;
      end
      smlbu_pkg::FUNC_JZ, smlbu_pkg::FUNC_JNZ: begin
        next = skip;
        if (depth_q == 2'd0) begin
          err = smlbu_pkg::ERR_PARAM_UNDER;
        end else begin
          pops = 2'd1;
          if ((top == '0) == (func_q == smlbu_pkg::FUNC_JZ)) begin
            next = tgt;
          end
        end
      end
      smlbu_pkg::FUNC_DO, smlbu_pkg::FUNC_PLUS_DO, smlbu_pkg::FUNC_MINUS_DO: begin
        next = (func_q == smlbu_pkg::FUNC_DO) ? opaddr : skip;
        if (depth_q < 2'd2) begin
          err = smlbu_pkg::ERR_PARAM_UNDER;
        end else begin
          pops = 2'd2;
          if (!room) begin
            err = smlbu_pkg::ERR_RET_OVER;
          end else begin
            push = 1'b1;
            if (func_q == smlbu_pkg::FUNC_PLUS_DO && top >= second) begin
              next = tgt;
            end
            if (func_q == smlbu_pkg::FUNC_MINUS_DO && second >= top) begin
              next = tgt;
            end
          end
        end
      end
      smlbu_pkg::FUNC_LOOP, smlbu_pkg::FUNC_STEP_LOOP: begin
        next = skip;
        if (!have_pair) begin
          err = smlbu_pkg::ERR_RET_UNDER;
        end else if (is_step && depth_q == 2'd0) begin
          err = smlbu_pkg::ERR_PARAM_UNDER;
        end else begin
          pops    = is_step ? 2'd1 : 2'd0;
          loop_wr = 1'b1;
          if (!step_v[DW-1]) begin
            if (!(idx >= lim)) begin
              next = tgt;
            end
          end else if (!(lim >= idx)) begin
            next = tgt;
          end
        end
      end
      smlbu_pkg::FUNC_UNLOOP: begin
        next = opaddr;
        if (!have_pair) begin
          err = smlbu_pkg::ERR_RET_UNDER;
        end else begin
          pop_pair = 1'b1;
        end
      end
      smlbu_pkg::FUNC_OF: begin
        next = skip;
        if (depth_q < 2'd2) begin
          err = smlbu_pkg::ERR_PARAM_UNDER;
        end else if (top == second) begin
          pops = 2'd2;
        end else begin
          pops = 2'd1;
          next = tgt;
        end
      end
      default: begin
      end
    endcase
  end

  // return stack: limit below, index on top
  assign ram_raddr_a = IW'(count_q - CW'(2));
  assign ram_raddr_b = IW'(count_q - CW'(1));

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = IW'(count_q);
    ram_wdata = second;
    count_d   = count_q;
    if (cmd_i.push_hi) begin
      ram_we    = 1'b1;
      ram_waddr = IW'(count_q + CW'(1));
      ram_wdata = top;
      count_d   = count_q + CW'(2);
    end else if (cmd_i.exec) begin
      if (push) begin
        ram_we = 1'b1;
      end else if (loop_wr) begin
        ram_we    = 1'b1;
        ram_waddr = ram_raddr_b;
        ram_wdata = idx;
      end else if (pop_pair) begin
        count_d = count_q - CW'(2);
      end
    end
  end

  smlbu_ram #(
    .WIDTH (DW),
    .DEPTH (RSTACK_DEPTH)
  ) u_rstack (
    .clk_i     (clk_i),
    .we_i      (ram_we),
    .waddr_i   (ram_waddr),
    .wdata_i   (ram_wdata),
    .raddr_a_i (ram_raddr_a),
    .raddr_b_i (ram_raddr_b),
    .rdata_a_o (ram_rdata_a),
    .rdata_b_o (ram_rdata_b)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      count_q <= count_d;
      if (cmd_i.exec) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.exec) begin
      next_q <= next;
      pops_q <= pops;
      err_q  <= err;
    end
  end

  assign out_free        = !out_valid_q || out_ready_i;
  assign sts_o.out_free  = out_free;
  assign sts_o.push_pend = push;
  assign out_valid_o     = out_valid_q;
  assign out_data_o      = {4'b0000, err_q, pops_q, smlbu_pkg::PortAddrW'(next_q)};

  a_count_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    {1'b0, count_q} <= (CW + 1)'(RSTACK_DEPTH))
    else $error("return count beyond stack depth");

  a_count_even : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !count_q[0])
    else $error("return count holds a half pair");

  a_count_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!cmd_i.exec && !cmd_i.push_hi) |=> $stable(count_q))
    else $error("return count moved without a command");

  a_exec_free : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.exec |-> (!out_valid_q || out_ready_i))
    else $error("result overwritten before taken");

endmodule

`default_nettype wire

[sv/smlbu_ctrl.sv]
`default_nettype none

module smlbu_ctrl (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output logic                  in_ready_o,
  input  wire smlbu_pkg::sts_t  sts_i,
  output smlbu_pkg::cmd_t       cmd_o
);

  smlbu_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= smlbu_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d       = state_q;
    in_ready_o    = 1'b0;
    cmd_o.capture = 1'b0;
    cmd_o.exec    = 1'b0;
    cmd_o.push_hi = 1'b0;
    case (state_q)
      smlbu_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = smlbu_pkg::ST_EXEC;
        end
      end
      smlbu_pkg::ST_EXEC: begin
        if (sts_i.out_free) begin
          cmd_o.exec = 1'b1;
          state_d    = sts_i.push_pend ? smlbu_pkg::ST_PUSH : smlbu_pkg::ST_IDLE;
        end
      end
      smlbu_pkg::ST_PUSH: begin
        cmd_o.push_hi = 1'b1;
        state_d       = smlbu_pkg::ST_IDLE;
      end
      default: begin
        state_d = smlbu_pkg::ST_IDLE;
      end
    endcase
  end

  a_push_one : assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == smlbu_pkg::ST_PUSH |=> state_q == smlbu_pkg::ST_IDLE)
    else $error("second push lasted more than one cycle");

  a_exec_wait : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == smlbu_pkg::ST_EXEC && !sts_i.out_free) |=> state_q == smlbu_pkg::ST_EXEC)
    else $error("left execute while result stalled");

  a_push_cause : assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == smlbu_pkg::ST_PUSH |->
      ($past(state_q) == smlbu_pkg::ST_EXEC && $past(sts_i.push_pend)))
    else $error("second push without a pushing word");

endmodule

`default_nettype wire

[sv/stack_machine_loop_branch_unit_core.sv]
// Flow: an item is captured in idle and evaluated in execute, which waits while the output
// stalls; result valid is registered as it executes. Input is ready only in idle; DO, +DO and
// -DO that push add a push state for the second return-stack write on the one write port.
// Reset: asynchronous, active low; clears the return count (stack empty), the
// controller and the result valid; stack memory contents are not cleared.
`default_nettype none

module stack_machine_loop_branch_unit_core #(
  parameter int unsigned RSTACK_DEPTH = smlbu_pkg::RstackDepth,
  parameter int unsigned DATA_WIDTH   = smlbu_pkg::DataWidth,
  parameter int unsigned ADDR_WIDTH   = smlbu_pkg::AddrWidth
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            s_axis_tvalid,
  output logic                                 s_axis_tready,
  // operand_addr, target, top_value, second_value, param_depth
  input  wire logic [smlbu_pkg::InDataW-1:0]   s_axis_tdata,
  // func
  input  wire logic [smlbu_pkg::FuncW-1:0]     s_axis_tuser,
  output logic                                 m_axis_tvalid,
  input  wire logic                            m_axis_tready,
  // next_addr, pop_count, error_code
  output logic [smlbu_pkg::OutDataW-1:0]       m_axis_tdata
);

  smlbu_pkg::cmd_t cmd;
  smlbu_pkg::sts_t sts;

  smlbu_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  smlbu_dpath #(
    .RSTACK_DEPTH (RSTACK_DEPTH),
    .DATA_WIDTH   (DATA_WIDTH),
    .ADDR_WIDTH   (ADDR_WIDTH)
  ) u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .in_user_i   (s_axis_tuser),
    .in_data_i   (s_axis_tdata),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_data_o  (m_axis_tdata)
  );

endmodule

`default_nettype wire

[test/loop_branch_check_pkg.sv]
package loop_branch_check_pkg;

  import smlbu_pkg::*;

  typedef struct packed {
    logic [FuncW-1:0]     func;
    logic [PortAddrW-1:0] opaddr;
    logic [PortAddrW-1:0] target;
    logic [ValueW-1:0]    top;
    logic [ValueW-1:0]    second;
    logic [DepthW-1:0]    depth;
  } instr_t;

  typedef struct packed {
    logic [PortAddrW-1:0] next_addr;
    logic [PopW-1:0]      pops;
    err_e                 err;
  } flow_t;

  class branch_flow_scoreboard;
    logic [DataWidth-1:0] loop_stack [RstackDepth];
    int unsigned          stack_used;
    flow_t                expected_flow [$];
    int unsigned          mismatches;

    function new();
      stack_used  = 0;
      mismatches  = 0;
    endfunction

    function int unsigned pending();
      return expected_flow.size();
    endfunction

    function void take_instr(instr_t it);
      flow_t                r;
      logic [PortAddrW-1:0] skip;
      logic [DataWidth-1:0] step;
      logic [DataWidth-1:0] idx;
      logic [DataWidth-1:0] lim;
      skip        = it.opaddr + PortAddrW'(2);
      r.next_addr = it.opaddr;
      r.pops      = '0;
      r.err       = ERR_OK;
      case (it.func)
        FUNC_JMP: r.next_addr = it.target;
        FUNC_JZ, FUNC_JNZ: begin
          r.next_addr = skip;
          if (it.depth < 1) begin
            r.err = ERR_PARAM_UNDER;
          end else begin
            r.pops = PopW'(1);
            if ((it.top == '0) == (it.func == FUNC_JZ)) r.next_addr = it.target;
          end
        end
        FUNC_DO, FUNC_PLUS_DO, FUNC_MINUS_DO: begin
          r.next_addr = (it.func == FUNC_DO) ? it.opaddr : skip;
          if (it.depth < 2) begin
            r.err = ERR_PARAM_UNDER;
          end else begin
            r.pops = PopW'(2);
            if (stack_used + 2 > RstackDepth) begin
              r.err = ERR_RET_OVER;
            end else begin
              loop_stack[stack_used]     = it.second;
              loop_stack[stack_used + 1] = it.top;
              stack_used += 2;
              if (it.func == FUNC_PLUS_DO && $signed(it.top) >= $signed(it.second))
                r.next_addr = it.target;
              if (it.func == FUNC_MINUS_DO && $signed(it.second) >= $signed(it.top))
                r.next_addr = it.target;
            end
          end
        end
        FUNC_LOOP, FUNC_STEP_LOOP: begin
          r.next_addr = skip;
          if (stack_used < 2) begin
            r.err = ERR_RET_UNDER;
          end else if (it.func == FUNC_STEP_LOOP && it.depth < 1) begin
            r.err = ERR_PARAM_UNDER;
          end else begin
            if (it.func == FUNC_STEP_LOOP) begin
              step   = it.top;
              r.pops = PopW'(1);
            end else begin
              step = DataWidth'(1);
            end
            lim = loop_stack[stack_used - 2];
            idx = loop_stack[stack_used - 1] + step;
            loop_stack[stack_used - 1] = idx;
            if (!step[DataWidth-1]) begin
              if (!($signed(idx) >= $signed(lim))) r.next_addr = it.target;
            end else begin
              if (!($signed(lim) >= $signed(idx))) r.next_addr = it.target;
            end
          end
        end
        FUNC_UNLOOP: begin
          if (stack_used < 2) r.err = ERR_RET_UNDER;
          else stack_used -= 2;
        end
        FUNC_OF: begin
          r.next_addr = skip;
          if (it.depth < 2) begin
            r.err = ERR_PARAM_UNDER;
          end else if (it.top == it.second) begin
            r.pops = PopW'(2);
          end else begin
            r.pops      = PopW'(1);
            r.next_addr = it.target;
          end
        end
        default: ;
      endcase
      expected_flow.push_back(r);
    endfunction

    function void check_flow(logic [OutDataW-1:0] word);
      flow_t exp_r;
      flow_t got;
      got.next_addr = word[15:0];
      got.pops      = word[17:16];
      got.err       = err_e'(word[19:18]);
      if (expected_flow.size() == 0) begin
        $display("%0t: result with nothing pending: next_addr %h pops %0d err %0d",
                 $time, got.next_addr, got.pops, got.err);
        mismatches++;
        return;
      end
      exp_r = expected_flow.pop_front();
      if (got.next_addr !== exp_r.next_addr) begin
        $display("%0t: next_addr expected %h actual %h", $time, exp_r.next_addr, got.next_addr);
        mismatches++;
      end
      if (got.pops !== exp_r.pops) begin
        $display("%0t: pop_count expected %0d actual %0d", $time, exp_r.pops, got.pops);
        mismatches++;
      end
      if (got.err !== exp_r.err) begin
        $display("%0t: error_code expected %0d actual %0d", $time, exp_r.err, got.err);
        mismatches++;
      end
    endfunction
  endclass

endpackage

[test/tb_stack_machine_loop_branch_unit_core.sv]
module tb_stack_machine_loop_branch_unit_core;

  timeunit 1ns;
  timeprecision 1ps;

  import smlbu_pkg::*;
  import loop_branch_check_pkg::*;

  localparam int unsigned   DirectedCount  = 26;
  localparam int unsigned   RandomItems    = 400;
  localparam int unsigned   HoldOffStart   = 150;
  localparam int unsigned   HoldOffCycles  = 300;
  localparam int unsigned   CycleLimit     = 300000;
  localparam int unsigned   DrainCycles    = 10;
  localparam logic [3:0]    FirstSpareFunc = 4'd10;
  localparam logic [3:0]    LastSpareFunc  = 4'd15;

  logic                clk_i         = 1'b0;
  logic                rst_ni        = 1'b0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [InDataW-1:0]  s_axis_tdata  = '0;
  logic [FuncW-1:0]    s_axis_tuser  = '0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [OutDataW-1:0] m_axis_tdata;

  branch_flow_scoreboard sb = new();

  int unsigned instrs_sent = 0;
  int unsigned cycle_count = 0;
  bit          sender_calm = 1'b0;
  bit          hold_off    = 1'b0;
  int unsigned stall_left  = 0;
  int unsigned flow_left   = 0;
  int unsigned ready_roll;

  stack_machine_loop_branch_unit_core dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) sb.check_flow(m_axis_tdata);
      if (flow_left > 0) begin
        flow_left--;
        m_axis_tready <= !hold_off;
      end else if (stall_left > 0) begin
        stall_left--;
        m_axis_tready <= 1'b0;
      end else begin
        ready_roll = $urandom_range(0, 99);
        if (ready_roll < 15) flow_left = $urandom_range(20, 80);
        else if (ready_roll < 55) stall_left = $urandom_range(1, 3);
        else if (ready_roll < 60) stall_left = $urandom_range(15, 50);
        m_axis_tready <= !hold_off && stall_left == 0;
      end
    end
  end

  initial begin
    wait (instrs_sent >= HoldOffStart);
    @(posedge clk_i);
    hold_off <= 1'b1;
    repeat (HoldOffCycles) @(posedge clk_i);
    hold_off <= 1'b0;
  end

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic logic [ValueW-1:0] loop_value();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r < 6) return ValueW'($urandom_range(0, 16)) - ValueW'(8);
    if (r < 8) return 32'h7FFF_FFF8 + ValueW'($urandom_range(0, 15));
    return $urandom;
  endfunction

  function automatic logic [PortAddrW-1:0] any_addr();
    if ($urandom_range(0, 7) == 0) return 16'hFFFE + PortAddrW'($urandom_range(0, 1));
    return PortAddrW'($urandom_range(0, 65535));
  endfunction

  task automatic send_instr(input instr_t it);
    int unsigned gap;
    gap = sender_calm ? 0 : pick_gap();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {6'b0, it.depth, it.second, it.top, it.target, it.opaddr};
    s_axis_tuser  <= it.func;
    do @(posedge clk_i); while (!s_axis_tready);
    sb.take_instr(it);
    instrs_sent++;
  endtask

  task automatic issue(input logic [FuncW-1:0] f, input logic [PortAddrW-1:0] addr,
                       input logic [PortAddrW-1:0] tgt, input logic [ValueW-1:0] top,
                       input logic [ValueW-1:0] second, input logic [DepthW-1:0] depth);
    instr_t it;
    it.func   = f;
    it.opaddr = addr;
    it.target = tgt;
    it.top    = top;
    it.second = second;
    it.depth  = depth;
    send_instr(it);
  endtask

  task automatic issue_random(input bit branch_only);
    logic [FuncW-1:0]  f;
    logic [ValueW-1:0] top;
    logic [ValueW-1:0] second;
    if (branch_only) begin
      case ($urandom_range(0, 3))
        0:       f = FUNC_JMP;
        1:       f = FUNC_JZ;
        2:       f = FUNC_JNZ;
        default: f = FUNC_OF;
      endcase
    end else if ($urandom_range(0, 99) < 85) begin
      f = FuncW'($urandom_range(FUNC_JMP, FUNC_OF));
    end else begin
      f = FuncW'($urandom_range(FirstSpareFunc, LastSpareFunc));
    end
    top    = ($urandom_range(0, 2) == 0) ? '0 : $urandom;
    second = ($urandom_range(0, 2) == 0) ? top : $urandom;
    issue(f, any_addr(), any_addr(), top, second, DepthW'($urandom_range(0, 2)));
  endtask

  task automatic run_loop_sequence();
    logic [FuncW-1:0]  do_func;
    logic [ValueW-1:0] limit;
    logic [ValueW-1:0] index;
    logic [ValueW-1:0] step;
    logic [DepthW-1:0] depth;
    int unsigned       turns;
    do_func = FuncW'(FUNC_DO) + FuncW'($urandom_range(0, 2));
    limit   = loop_value();
    index   = ($urandom_range(0, 3) == 0) ? loop_value()
                                          : limit - ValueW'($urandom_range(0, 6));
    depth   = ($urandom_range(0, 9) == 0) ? DepthW'($urandom_range(0, 1)) : 2'd2;
    issue(do_func, any_addr(), any_addr(), index, limit, depth);
    turns = $urandom_range(1, 6);
    repeat (turns) begin
      if ($urandom_range(0, 3) == 0) issue_random(1'b1);
      if ($urandom_range(0, 9) < 7) begin
        issue(FUNC_LOOP, any_addr(), any_addr(), $urandom, $urandom,
              DepthW'($urandom_range(0, 2)));
      end else begin
        step  = ($urandom_range(0, 3) == 0) ? loop_value()
                                            : ValueW'($urandom_range(0, 6)) - ValueW'(3);
        depth = ($urandom_range(0, 9) == 0) ? 2'd0 : DepthW'($urandom_range(1, 2));
        issue(FUNC_STEP_LOOP, any_addr(), any_addr(), step, $urandom, depth);
      end
    end
    if ($urandom_range(0, 9) < 8) issue(FUNC_UNLOOP, any_addr(), any_addr(), $urandom, $urandom,
                                        DepthW'($urandom_range(0, 2)));
  endtask

  task automatic run_fill_burst();
    repeat (RstackDepth / 2 + 2)
      issue(FUNC_DO, any_addr(), any_addr(), loop_value(), loop_value(), 2'd2);
    repeat (RstackDepth / 2 + 3)
      issue(FUNC_UNLOOP, any_addr(), any_addr(), $urandom, $urandom, 2'd2);
  endtask

  initial begin
    int unsigned pick;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    issue(FUNC_LOOP,      16'hFFFF, 16'h1234, 32'd0,         32'd0,         2'd2);
    issue(FUNC_STEP_LOOP, 16'h0100, 16'h0200, 32'd1,         32'd0,         2'd0);
    issue(FUNC_UNLOOP,    16'h0010, 16'h0020, 32'd0,         32'd0,         2'd2);
    issue(FUNC_JMP,       16'h0000, 16'h0000, 32'h7FFF_FFFF, 32'h8000_0000, 2'd0);
    issue(FUNC_JMP,       16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 2'd2);
    issue(FUNC_JZ,        16'hFFFE, 16'h5555, 32'd0,         32'd0,         2'd0);
    issue(FUNC_JZ,        16'h2000, 16'hAAAA, 32'd0,         32'd7,         2'd1);
    issue(FUNC_JZ,        16'h2004, 16'h0F0F, 32'h8000_0000, 32'd0,         2'd2);
    issue(FUNC_JNZ,       16'h3000, 16'hF0F0, 32'd0,         32'd1,         2'd1);
    issue(FUNC_JNZ,       16'h3004, 16'h00FF, 32'hFFFF_FFFF, 32'd0,         2'd2);
    issue(FUNC_DO,        16'h4000, 16'h0000, 32'd0,         32'd3,         2'd1);
    issue(FUNC_DO,        16'h4000, 16'h0000, 32'd0,         32'd3,         2'd2);
    issue(FUNC_LOOP,      16'h4010, 16'h4002, 32'd0,         32'd0,         2'd0);
    issue(FUNC_STEP_LOOP, 16'h4010, 16'h4002, 32'd2,         32'd0,         2'd0);
    issue(FUNC_STEP_LOOP, 16'h4010, 16'h4002, 32'd2,         32'd0,         2'd1);
    issue(FUNC_UNLOOP,    16'h4014, 16'h0000, 32'd0,         32'd0,         2'd0);
    issue(FUNC_PLUS_DO,   16'h5000, 16'h5100, 32'd5,         32'd5,         2'd2);
    issue(FUNC_MINUS_DO,  16'h6000, 16'h6100, 32'h8000_0000, 32'h7FFF_FFFF, 2'd2);
    issue(FUNC_STEP_LOOP, 16'h6010, 16'h6002, 32'hFFFF_FFFF, 32'd0,         2'd2);
    issue(FUNC_UNLOOP,    16'h6014, 16'h0000, 32'd0,         32'd0,         2'd0);
    issue(FUNC_UNLOOP,    16'h5014, 16'h0000, 32'd0,         32'd0,         2'd0);
    issue(FUNC_OF,        16'h7000, 16'h7100, 32'hDEAD_BEEF, 32'hDEAD_BEEF, 2'd2);
    issue(FUNC_OF,        16'h7004, 16'h7200, 32'd1,         32'd2,         2'd2);
    issue(FUNC_OF,        16'h7008, 16'h7300, 32'd1,         32'd1,         2'd1);
    issue(FirstSpareFunc, 16'h8000, 16'h8100, 32'd0,         32'd0,         2'd2);
    issue(LastSpareFunc,  16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF, 32'd0,         2'd1);

    while (instrs_sent < DirectedCount + RandomItems) begin
      sender_calm = ($urandom_range(0, 4) == 0);
      pick = $urandom_range(0, 99);
      if (pick < 60) run_loop_sequence();
      else if (pick < 65) run_fill_burst();
      else repeat ($urandom_range(1, 6)) issue_random(1'b0);
    end
    s_axis_tvalid <= 1'b0;

    while (sb.pending() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
